// ----- rtl/tri_pkg.sv -----
// shared types and constants for the trie insert and lookup block
package tri_pkg;

    localparam int LETTER_W = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_LOOK,
        S_ALLOC,
        S_FINISH,
        S_VALUE,
        S_EMIT
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;        // latch an accepted word
        logic fail;        // mark the walk as failed
        logic take;        // follow the existing child
        logic link;        // write the new child link into the parent row
        logic clear_new;   // zero the new node and bump the node count
        logic root_clear;  // zero the root after reset
        logic val_write;   // store the key value at the final node
        logic val_take;    // capture the stored value
        logic emit;        // load the result register and rewind the walk
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic mode;
        logic last;
        logic failed;
        logic letter_bad;
        logic child_zero;
        logic full;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/tri_ifs.sv -----
// valid/ready channel interfaces for letter words and result words
interface tri_req_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [tri_pkg::LETTER_W-1:0]  letter;
    logic                          is_first;
    logic                          is_last;
    logic [tri_pkg::VALUE_W-1:0]   value;

    modport source (output valid, mode, letter, is_first, is_last, value, input ready);
    modport sink   (input valid, mode, letter, is_first, is_last, value, output ready);
endinterface

interface tri_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [tri_pkg::VALUE_W-1:0]   found_value;
    logic [tri_pkg::STATUS_W-1:0]  status;

    modport source (output valid, found_value, status, input ready);
    modport sink   (input valid, found_value, status, output ready);
endinterface

// ----- rtl/tri_ram.sv -----
// generic single-port ram with registered read
module tri_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/tri_dp.sv -----
// trie datapath: walk registers, node count, child row and value memories, result register
module tri_dp #(
    parameter int NODE_COUNT    = 4096,
    parameter int ALPHABET_SIZE = 26
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tri_pkg::t_cmd                 i_cmd,
    output tri_pkg::t_sts                 o_sts,
    input  logic                          i_mode,
    input  logic [tri_pkg::LETTER_W-1:0]  i_letter,
    input  logic                          i_is_first,
    input  logic                          i_is_last,
    input  logic [tri_pkg::VALUE_W-1:0]   i_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [tri_pkg::VALUE_W-1:0]   o_found_value,
    output logic [tri_pkg::STATUS_W-1:0]  o_status
);

    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam int CNT_W = $clog2(NODE_COUNT + 1);
    localparam int SEL_W = $clog2(ALPHABET_SIZE);
    localparam int ROW_W = ALPHABET_SIZE * IDX_W;

    logic                         r_mode;
    logic [tri_pkg::LETTER_W-1:0] r_letter;
    logic                         r_last;
    logic [tri_pkg::VALUE_W-1:0]  r_value;
    logic [IDX_W-1:0]             r_node;
    logic                         r_failed;
    logic [CNT_W-1:0]             r_nodes_used;
    logic [tri_pkg::VALUE_W-1:0]  r_found;
    logic                         r_out_valid;
    logic [tri_pkg::VALUE_W-1:0]  r_out_found;
    logic [tri_pkg::STATUS_W-1:0] r_out_status;

    logic [ROW_W-1:0]             row_rd;
    logic [ROW_W-1:0]             row_wd;
    logic [ROW_W-1:0]             row_linked;
    logic                         row_we;
    logic [IDX_W-1:0]             child;
    logic [IDX_W-1:0]             new_idx;
    logic [SEL_W-1:0]             sel;
    logic [tri_pkg::VALUE_W-1:0]  val_rd;
    logic [tri_pkg::VALUE_W-1:0]  val_wd;
    logic                         val_we;
    logic                         out_free;

    assign sel     = SEL_W'(r_letter);
    assign new_idx = IDX_W'(r_nodes_used);

    // pick the child entry of the current letter and build the row with the new link
    always_comb begin
        child      = '0;
        row_linked = row_rd;
        for (int i = 0; i < ALPHABET_SIZE; i++) begin
            if (sel == SEL_W'(i)) begin
                child = row_rd[i*IDX_W +: IDX_W];
                row_linked[i*IDX_W +: IDX_W] = new_idx;
            end
        end
    end

    // both memories are addressed by the walk node; a new node is zeroed once allocated
    assign row_we = i_cmd.link | i_cmd.clear_new | i_cmd.root_clear;
    assign row_wd = i_cmd.link ? row_linked : '0;
    assign val_we = i_cmd.val_write | i_cmd.clear_new | i_cmd.root_clear;
    assign val_wd = i_cmd.val_write ? r_value : '0;

    tri_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NODE_COUNT)
    ) u_child_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_addr  (r_node),
        .i_wdata (row_wd),
        .o_rdata (row_rd)
    );

    tri_ram #(
        .WIDTH (tri_pkg::VALUE_W),
        .DEPTH (NODE_COUNT)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_addr  (r_node),
        .i_wdata (val_wd),
        .o_rdata (val_rd)
    );

    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node       <= '0;
            r_failed     <= 1'b0;
            r_nodes_used <= CNT_W'(1);
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (i_is_first) begin
                    r_node   <= '0;
                    r_failed <= 1'b0;
                end
            end else if (i_cmd.take) begin
                r_node <= child;
            end else if (i_cmd.link) begin
                r_node <= new_idx;
            end else if (i_cmd.emit) begin
                r_node   <= '0;
                r_failed <= 1'b0;
            end
            if (i_cmd.fail) begin
                r_failed <= 1'b1;
            end
            if (i_cmd.clear_new) begin
                r_nodes_used <= r_nodes_used + CNT_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_mode;
            r_letter <= i_letter;
            r_last   <= i_is_last;
            r_value  <= i_value;
        end
        if (i_cmd.val_take) begin
            r_found <= val_rd;
        end
        if (i_cmd.emit) begin
            r_out_found <= (!r_mode && !r_failed) ? r_found : '0;
            if (r_failed) begin
                r_out_status <= r_mode ? tri_pkg::ST_FULL : tri_pkg::ST_MISS;
            end else begin
                r_out_status <= tri_pkg::ST_OK;
            end
        end
    end

    assign o_sts.mode       = r_mode;
    assign o_sts.last       = r_last;
    assign o_sts.failed     = r_failed;
    assign o_sts.letter_bad = (32'(r_letter) >= 32'(ALPHABET_SIZE));
    assign o_sts.child_zero = (child == '0);
    assign o_sts.full       = (r_nodes_used >= CNT_W'(NODE_COUNT));
    assign o_sts.out_free   = out_free;

    assign o_valid       = r_out_valid;
    assign o_found_value = r_out_found;
    assign o_status      = r_out_status;

endmodule

// ----- rtl/tri_ctrl.sv -----
// trie controller: sequences row read, link and node clear per letter, and value access per key
module tri_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tri_pkg::t_sts i_sts,
    output tri_pkg::t_cmd o_cmd
);

    tri_pkg::t_state r_state;
    tri_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tri_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            tri_pkg::S_INIT: begin
                o_cmd.root_clear = 1'b1;
                n_state          = tri_pkg::S_IDLE;
            end
            tri_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = tri_pkg::S_READ;
                end
            end
            tri_pkg::S_READ: begin
                // row read of the current node is in flight; a dead walk or a bad letter skips the lookup
                if (i_sts.failed) begin
                    n_state = tri_pkg::S_FINISH;
                end else if (i_sts.letter_bad) begin
                    o_cmd.fail = 1'b1;
                    n_state    = tri_pkg::S_FINISH;
                end else begin
                    n_state = tri_pkg::S_LOOK;
                end
            end
            tri_pkg::S_LOOK: begin
                if (!i_sts.child_zero) begin
                    o_cmd.take = 1'b1;
                    n_state    = tri_pkg::S_FINISH;
                end else if (i_sts.mode && !i_sts.full) begin
                    o_cmd.link = 1'b1;
                    n_state    = tri_pkg::S_ALLOC;
                end else begin
                    o_cmd.fail = 1'b1;
                    n_state    = tri_pkg::S_FINISH;
                end
            end
            tri_pkg::S_ALLOC: begin
                o_cmd.clear_new = 1'b1;
                n_state         = tri_pkg::S_FINISH;
            end
            tri_pkg::S_FINISH: begin
                priority if (!i_sts.last) begin
                    n_state = tri_pkg::S_IDLE;
                end else if (i_sts.failed) begin
                    n_state = tri_pkg::S_EMIT;
                end else if (i_sts.mode) begin
                    o_cmd.val_write = 1'b1;
                    n_state         = tri_pkg::S_EMIT;
                end else begin
                    n_state = tri_pkg::S_VALUE;
                end
            end
            tri_pkg::S_VALUE: begin
                o_cmd.val_take = 1'b1;
                n_state        = tri_pkg::S_EMIT;
            end
            tri_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = tri_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tri_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/trie_insert_and_lookup.sv -----
// Trie insert and lookup over a node table: one letter word in, one result word per key.
// For each letter word the current node's child row is read from a single-port memory
// with registered read; when an insert finds no child, the new link is written back to
// that row, and the new node's row and value are zeroed in the following cycle. Once the
// walk has failed, later letters of the key skip the row lookup. The last letter of a key
// writes the value for a live insert or reads the value memory for a live search, then
// waits, if need be, for the result register to drain. After reset the root is cleared
// before the first letter is taken. Keys must not be empty; a full table drops the insert
// with status 2, a missing child on search gives status 1 and found_value 0.
module trie_insert_and_lookup #(
    parameter int NODE_COUNT    = 4096,
    parameter int ALPHABET_SIZE = 26
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tri_req_if.sink   i_req,
    tri_rsp_if.source o_rsp
);

    tri_pkg::t_cmd cmd;
    tri_pkg::t_sts sts;
    logic          in_ready;

    tri_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tri_dp #(
        .NODE_COUNT    (NODE_COUNT),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_mode        (i_req.mode),
        .i_letter      (i_req.letter),
        .i_is_first    (i_req.is_first),
        .i_is_last     (i_req.is_last),
        .i_value       (i_req.value),
        .o_valid       (o_rsp.valid),
        .i_ready       (o_rsp.ready),
        .o_found_value (o_rsp.found_value),
        .o_status      (o_rsp.status)
    );

    assign i_req.ready = in_ready;

endmodule

// ----- bench/trie_lookup_checker.sv -----
// checker for the trie block: follows both channels, predicts each key's result, compares
module trie_lookup_checker #(
    parameter int NODE_COUNT    = 4096,
    parameter int ALPHABET_SIZE = 26
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tri_req_if   i_req,
    tri_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import tri_pkg::*;

    localparam int NODE_W = $clog2(NODE_COUNT);

    typedef struct {
        logic [VALUE_W-1:0]  found_value;
        logic [STATUS_W-1:0] status;
    } t_lookup;

    logic [NODE_W-1:0]  child_link [NODE_COUNT*ALPHABET_SIZE];
    logic [VALUE_W-1:0] node_data  [NODE_COUNT];
    int unsigned        nodes_taken;
    int unsigned        walk_node;
    logic               walk_dead;
    t_lookup            lookups_due [$];
    int                 mismatches;

    // one letter word: move the walk and, on the last letter, queue the key's result
    task automatic take_letter(input logic ins, input logic [LETTER_W-1:0] letter,
                               input logic first, input logic last,
                               input logic [VALUE_W-1:0] value);
        int unsigned slot;
        int unsigned child;
        t_lookup     res;
        if (first) begin
            walk_node = 0;
            walk_dead = 1'b0;
        end
        if (!walk_dead) begin
            if (letter >= ALPHABET_SIZE) begin
                walk_dead = 1'b1;
            end else begin
                slot  = walk_node * ALPHABET_SIZE + letter;
                child = child_link[slot];
                // zero link means no child: only an insert with room left may add one
                if (child == 0 && (!ins || nodes_taken >= NODE_COUNT)) begin
                    walk_dead = 1'b1;
                end else begin
                    if (child == 0) begin
                        child            = nodes_taken;
                        child_link[slot] = NODE_W'(child);
                        node_data[child] = '0;
                        nodes_taken++;
                    end
                    walk_node = child;
                end
            end
        end
        if (last) begin
            res.found_value = '0;
            res.status      = ST_OK;
            if (ins) begin
                if (walk_dead) res.status = ST_FULL;
                else node_data[walk_node] = value;
            end else if (walk_dead) begin
                res.status = ST_MISS;
            end else begin
                res.found_value = node_data[walk_node];
            end
            lookups_due.push_back(res);
            walk_node = 0;
            walk_dead = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_lookup want;
        if (!i_rst_n) begin
            foreach (child_link[i]) child_link[i] = '0;
            foreach (node_data[i]) node_data[i] = '0;
            nodes_taken = 1;
            walk_node   = 0;
            walk_dead   = 1'b0;
            mismatches  = 0;
            lookups_due.delete();
        end else begin
            // a result can never belong to a letter taken at the same edge
            if (i_rsp.valid && i_rsp.ready) begin
                if (lookups_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("result word with none expected: found_value %h status %0d",
                                 i_rsp.found_value, i_rsp.status);
                    mismatches++;
                end else begin
                    want = lookups_due.pop_front();
                    if (want.found_value !== i_rsp.found_value || want.status !== i_rsp.status)
                    begin
                        if (mismatches < 10)
                            $display({"result mismatch: expected found_value %h status %0d,",
                                      " got found_value %h status %0d"},
                                     want.found_value, want.status,
                                     i_rsp.found_value, i_rsp.status);
                        mismatches++;
                    end
                end
            end
            if (i_req.valid && i_req.ready)
                take_letter(i_req.mode, i_req.letter, i_req.is_first, i_req.is_last,
                            i_req.value);
        end
        o_fail_count <= mismatches;
        o_pending    <= lookups_due.size();
    end

endmodule

// ----- bench/trie_insert_and_lookup_test.sv -----
// top of the trie testbench: clock, reset, letter stimulus, result stalls and the verdict
module trie_insert_and_lookup_test;
    timeunit 1ns;
    timeprecision 1ps;
    import tri_pkg::*;

    localparam logic MODE_SEARCH = 1'b0;
    localparam logic MODE_INSERT = 1'b1;
    localparam int   KEY_MAX     = 32;
    localparam int   POOL_MAX    = 64;
    localparam int   FILL_LEN    = 30;
    localparam int   RANDOM_END  = 480;
    localparam int   FILL_END    = 680;
    localparam int   TAIL_END    = 800;
    localparam int   CYCLE_LIMIT = 1000000;

    typedef logic [LETTER_W-1:0] t_key [KEY_MAX];

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic allow_idle;
    int   stall_left;
    int   cycle_count;
    int   words_sent;
    int   fail_count;
    int   pending;
    t_key pool_key [POOL_MAX];
    int   pool_len [POOL_MAX];
    int   pool_count;

    tri_req_if req_ch ();
    tri_rsp_if rsp_ch ();

    trie_insert_and_lookup dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    trie_lookup_checker lookup_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2ns i_clk = 1'b1;
        #2ns i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side stalls in random bursts while idling is allowed
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (allow_idle && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 7);
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // present one letter word and hold it until taken; valid stays high on return
    task automatic send_word(input logic mode, input logic [LETTER_W-1:0] letter,
                             input logic first, input logic last,
                             input logic [VALUE_W-1:0] value);
        if (allow_idle && $urandom_range(0, 4) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.mode     <= mode;
        req_ch.letter   <= letter;
        req_ch.is_first <= first;
        req_ch.is_last  <= last;
        req_ch.value    <= value;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_key(input t_key letters, input int len, input logic ins,
                            input logic [VALUE_W-1:0] value, input logic mixed,
                            input logic no_first, input logic closed);
        for (int i = 0; i < len; i++)
            send_word(mixed ? logic'($urandom_range(0, 1)) : ins, letters[i],
                      i == 0 && !no_first, closed && i == len - 1,
                      (i == len - 1) ? value : $urandom());
    endtask

    // sender waits until every outstanding result has come back
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // one key of random kind: mostly inserts and searches of remembered keys, some noise
    task automatic random_key();
        t_key               letters;
        int                 len;
        int                 pick;
        int                 slot;
        logic [VALUE_W-1:0] value;
        pick  = $urandom_range(0, 99);
        len   = $urandom_range(1, 5);
        value = pick_value();
        // narrow letters give shared prefixes and frequent hits
        foreach (letters[i])
            letters[i] = ($urandom_range(0, 4) == 0) ? LETTER_W'($urandom_range(0, 25))
                                                     : LETTER_W'($urandom_range(0, 3));
        if (pick < 35) begin
            if (pool_count < POOL_MAX) begin
                slot = pool_count;
                pool_count++;
            end else begin
                slot = $urandom_range(0, POOL_MAX - 1);
            end
            pool_key[slot] = letters;
            pool_len[slot] = len;
            send_key(letters, len, MODE_INSERT, value, 1'b0, 1'b0, 1'b1);
        end else if (pick < 70 && pool_count > 0) begin
            slot = $urandom_range(0, pool_count - 1);
            send_key(pool_key[slot], pool_len[slot], MODE_SEARCH, value, 1'b0, 1'b0, 1'b1);
        end else if (pick < 80 && pool_count > 0) begin
            // prefix of a stored key: node may exist without a value
            slot = $urandom_range(0, pool_count - 1);
            send_key(pool_key[slot], $urandom_range(1, pool_len[slot]), MODE_SEARCH, value,
                     1'b0, 1'b0, 1'b1);
        end else if (pick < 86) begin
            letters[$urandom_range(0, len - 1)] = LETTER_W'($urandom_range(26, 31));
            send_key(letters, len, logic'($urandom_range(0, 1)), value, 1'b0, 1'b0, 1'b1);
        end else if (pick < 92) begin
            send_key(letters, len, logic'($urandom_range(0, 1)), value, 1'b1, 1'b0, 1'b1);
        end else if (pick < 96) begin
            // abandoned key with no last mark, then a fresh key restarts at the root
            send_key(letters, $urandom_range(1, 3), logic'($urandom_range(0, 1)), value,
                     1'b1, 1'b0, 1'b0);
            send_key(letters, len, MODE_SEARCH, value, 1'b0, 1'b0, 1'b1);
        end else begin
            send_key(letters, len, logic'($urandom_range(0, 1)), value, 1'b0, 1'b1, 1'b1);
        end
    endtask

    initial begin : stimulus
        t_key fill_key;
        i_rst_n         = 1'b0;
        allow_idle      = 1'b0;
        stall_left      = 0;
        cycle_count     = 0;
        words_sent      = 0;
        pool_count      = 0;
        req_ch.valid    = 1'b0;
        req_ch.mode     = MODE_SEARCH;
        req_ch.letter   = '0;
        req_ch.is_first = 1'b0;
        req_ch.is_last  = 1'b0;
        req_ch.value    = '0;
        rsp_ch.ready    = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty trie misses, then the letter and value extremes
        send_word(MODE_SEARCH, 0, 1'b1, 1'b1, $urandom());
        send_word(MODE_INSERT, 0, 1'b1, 1'b1, 32'hffff_ffff);
        send_word(MODE_SEARCH, 0, 1'b1, 1'b1, $urandom());
        send_word(MODE_INSERT, 25, 1'b1, 1'b1, 32'h0);
        send_word(MODE_INSERT, 25, 1'b1, 1'b0, $urandom());
        send_word(MODE_INSERT, 0, 1'b0, 1'b0, $urandom());
        send_word(MODE_INSERT, 25, 1'b0, 1'b1, 32'h1234_5678);
        // inner node created by the insert above but never given a value
        send_word(MODE_SEARCH, 25, 1'b1, 1'b0, $urandom());
        send_word(MODE_SEARCH, 0, 1'b0, 1'b1, $urandom());
        send_word(MODE_SEARCH, 25, 1'b1, 1'b0, $urandom());
        send_word(MODE_SEARCH, 0, 1'b0, 1'b0, $urandom());
        send_word(MODE_SEARCH, 25, 1'b0, 1'b1, $urandom());
        send_word(MODE_SEARCH, 25, 1'b1, 1'b0, $urandom());
        send_word(MODE_SEARCH, 1, 1'b0, 1'b1, $urandom());
        // letters past the alphabet
        send_word(MODE_INSERT, 0, 1'b1, 1'b0, $urandom());
        send_word(MODE_INSERT, 31, 1'b0, 1'b1, $urandom());
        send_word(MODE_SEARCH, 26, 1'b1, 1'b1, $urandom());
        // mode changes within a key
        send_word(MODE_SEARCH, 1, 1'b1, 1'b0, $urandom());
        send_word(MODE_INSERT, 2, 1'b0, 1'b1, $urandom());
        send_word(MODE_INSERT, 1, 1'b1, 1'b0, $urandom());
        send_word(MODE_SEARCH, 2, 1'b0, 1'b1, $urandom());
        // first mark in the middle restarts at the root
        send_word(MODE_INSERT, 3, 1'b1, 1'b0, $urandom());
        send_word(MODE_SEARCH, 25, 1'b1, 1'b1, $urandom());
        // key after a finished key without a first mark
        send_word(MODE_SEARCH, 0, 1'b0, 1'b1, $urandom());
        drain();

        allow_idle <= 1'b1;
        while (words_sent < RANDOM_END) begin
            if ($urandom_range(0, 29) == 0) allow_idle <= ($urandom_range(0, 3) != 0);
            random_key();
        end
        drain();

        // long fresh inserts grow deep branches of new nodes
        allow_idle <= 1'b1;
        while (words_sent < FILL_END) begin
            foreach (fill_key[i]) fill_key[i] = LETTER_W'($urandom_range(0, 25));
            send_key(fill_key, FILL_LEN, MODE_INSERT, pick_value(), 1'b0, 1'b0, 1'b1);
        end

        // last part of the run, no idling on either side
        allow_idle <= 1'b0;
        while (words_sent < TAIL_END) random_key();
        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
